// ===== sv/gsc_pkg.sv =====
// Shared constants and codes for the greedy state canonicalizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gsc_pkg;
   localparam int DEF_MAX_VARS   = 16;
   localparam int DEF_MAX_GENS   = 8;
   localparam int DEF_MAX_VALUES = 8;
   localparam int DEF_MAX_STEPS  = 32;

   localparam logic [1:0] ACT_VAR_MAP   = 2'd0;
   localparam logic [1:0] ACT_VALUE_MAP = 2'd1;
   localparam logic [1:0] ACT_ELEMENT   = 2'd2;

   localparam logic KIND_GEN  = 1'b0;
   localparam logic KIND_ELEM = 1'b1;

   localparam logic CSR_VAR_COUNT = 1'b0;
   localparam logic CSR_GEN_COUNT = 1'b1;

   localparam logic [4:0] VAR_COUNT_RESET = 5'd16;
   localparam logic [3:0] GEN_COUNT_RESET = 4'd0;
endpackage
`default_nettype wire

// ===== sv/greedy_state_canonicalizer.sv =====
// Greedy state canonicalizer: table memories, state vectors, round sequencer.
// Depends on gsc_pkg.
//
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/stall  | action gen_index var_index value_in mapped_to last_in
//  rsp     | out       | rsp_valid/stall  | kind position value_out overflow last_out
//  csr     | in        | csr_valid/ready  | csr_index csr_data
//
// Table loads and non-final elements are taken while idle. A final element starts a run:
// each round reads, per generator, the table memories through the memory port (apply)
// and compares the candidate with the state (cmp), then takes a round step.
// Element results leave one per cycle unless rsp_stall holds; a generator result reads the log first.
// Reset is synchronous; tables and vectors are undefined until written.
// rsp_stall holds the output register; req_stall is high for the whole run.
`timescale 1ns / 1ps
`default_nettype none
module greedy_state_canonicalizer #(
   parameter int MAX_VARS   = gsc_pkg::DEF_MAX_VARS,
   parameter int MAX_GENS   = gsc_pkg::DEF_MAX_GENS,
   parameter int MAX_VALUES = gsc_pkg::DEF_MAX_VALUES,
   parameter int MAX_STEPS  = gsc_pkg::DEF_MAX_STEPS
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [1:0] req_action,
   input  wire  [2:0] req_gen_index,
   input  wire  [3:0] req_var_index,
   input  wire  [2:0] req_value_in,
   input  wire  [3:0] req_mapped_to,
   input  wire        req_last_in,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic       rsp_kind,
   output logic [3:0] rsp_position,
   output logic [2:0] rsp_value_out,
   output logic       rsp_overflow,
   output logic       rsp_last_out,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire        csr_index,
   input  wire  [4:0] csr_data
);
   localparam int VMAP_DEPTH = MAX_GENS * MAX_VARS;
   localparam int XMAP_DEPTH = VMAP_DEPTH * MAX_VALUES;
   localparam int VMAP_AW    = $clog2(VMAP_DEPTH);
   localparam int XMAP_AW    = $clog2(XMAP_DEPTH);
   localparam int VIW        = $clog2(MAX_VARS);
   localparam int VCW        = $clog2(MAX_VARS + 1);
   localparam int GCW        = $clog2(MAX_GENS + 1);
   localparam int RCW        = $clog2(MAX_STEPS + 1);
   localparam int LAW        = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_APPLY, ST_CMP, ST_ROUND, ST_LOG_RD, ST_LOG_OUT, ST_ELEM_OUT
   } state_type;

   logic [3:0]     vmap_mem [VMAP_DEPTH];
   logic [2:0]     xmap_mem [XMAP_DEPTH];
   logic [GCW-1:0] log_mem  [MAX_STEPS];
   logic [2:0]     cur_ff  [MAX_VARS];
   logic [2:0]     cand_ff [MAX_VARS];
   logic [2:0]     chos_ff [MAX_VARS];

   state_type      state_ff;
   logic [4:0]     var_count_ff;
   logic [3:0]     gen_count_ff;
   logic [VCW-1:0] vi_ff;
   logic [GCW-1:0] gi_ff;
   logic [GCW-1:0] best_ff;
   logic [RCW-1:0] round_ff;
   logic [RCW-1:0] li_ff;
   logic           found_ff, over_ff, pend_ff, xbad_ff;
   logic [3:0]     vmap_q;
   logic [2:0]     xmap_q;
   logic [GCW-1:0] log_q;

   logic [VCW-1:0] nv;
   logic [GCW-1:0] ng;
   logic           out_free, req_fire, rsp_load;
   logic [VIW-1:0] vidx;
   logic [2:0]     cur_x;
   int             vaddr_i, xaddr_i;

   always_comb begin
      if (var_count_ff == 5'd0) begin
         nv = VCW'(1);
      end else if (int'(var_count_ff) > MAX_VARS) begin
         nv = VCW'(MAX_VARS);
      end else begin
         nv = VCW'(int'(var_count_ff));
      end
      ng = (int'(gen_count_ff) > MAX_GENS) ? GCW'(MAX_GENS) : GCW'(int'(gen_count_ff));
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid || !rsp_stall;
   assign rsp_load  = out_free && (state_ff == ST_LOG_OUT || state_ff == ST_ELEM_OUT);
   assign vidx      = vi_ff[VIW-1:0];
   assign cur_x     = cur_ff[vidx];

   always_ff @(posedge clock) begin
      if (reset) begin
         var_count_ff <= gsc_pkg::VAR_COUNT_RESET;
         gen_count_ff <= gsc_pkg::GEN_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gsc_pkg::CSR_VAR_COUNT: var_count_ff <= csr_data;
            gsc_pkg::CSR_GEN_COUNT: gen_count_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // table memories: load port in idle, read port during apply
   always_comb begin
      vaddr_i = int'(gi_ff) * MAX_VARS + int'(vi_ff);
      xaddr_i = vaddr_i * MAX_VALUES + int'(cur_x);
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_action == gsc_pkg::ACT_VAR_MAP && int'(req_gen_index) < MAX_GENS
          && int'(req_var_index) < MAX_VARS) begin
         vmap_mem[VMAP_AW'(int'(req_gen_index) * MAX_VARS + int'(req_var_index))]
            <= req_mapped_to;
      end
      if (req_fire && req_action == gsc_pkg::ACT_VALUE_MAP && int'(req_gen_index) < MAX_GENS
          && int'(req_var_index) < MAX_VARS && int'(req_value_in) < MAX_VALUES) begin
         xmap_mem[XMAP_AW'((int'(req_gen_index) * MAX_VARS + int'(req_var_index))
                  * MAX_VALUES + int'(req_value_in))] <= req_mapped_to[2:0];
      end
      vmap_q <= vmap_mem[VMAP_AW'(vaddr_i)];
      xmap_q <= xmap_mem[XMAP_AW'(xaddr_i)];
      log_q  <= log_mem[li_ff[LAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rsp_valid <= 1'b0;
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
         over_ff   <= 1'b0;
         round_ff  <= '0;
         vi_ff     <= '0;
         gi_ff     <= '0;
         li_ff     <= '0;
      end else begin
         if (rsp_valid && !rsp_stall && !rsp_load) begin
            rsp_valid <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_action == gsc_pkg::ACT_ELEMENT) begin
                  if (int'(req_var_index) < MAX_VARS) begin
                     cur_ff[VIW'(int'(req_var_index))] <= req_value_in;
                  end
                  if (req_last_in) begin
                     round_ff <= '0;
                     found_ff <= 1'b0;
                     over_ff  <= 1'b0;
                     gi_ff    <= '0;
                     vi_ff    <= '0;
                     pend_ff  <= 1'b0;
                     state_ff <= (ng == '0) ? ST_ROUND : ST_APPLY;
                  end
               end
            end
            ST_APPLY: begin
               if (pend_ff && int'(vmap_q) < int'(nv)) begin
                  cand_ff[VIW'(int'(vmap_q))] <= xbad_ff ? 3'd0 : xmap_q;
               end
               if (vi_ff < nv) begin
                  xbad_ff <= (int'(cur_x) >= MAX_VALUES);
                  vi_ff   <= vi_ff + 1'b1;
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     vi_ff    <= '0;
                     state_ff <= ST_CMP;
                  end
               end
            end
            ST_CMP: begin
               if (vi_ff == nv || cand_ff[vidx] != cur_x) begin
                  if (vi_ff != nv && cand_ff[vidx] < cur_x) begin
                     chos_ff  <= cand_ff;
                     best_ff  <= gi_ff;
                     found_ff <= 1'b1;
                  end
                  vi_ff    <= '0;
                  gi_ff    <= gi_ff + 1'b1;
                  state_ff <= (gi_ff + 1'b1 == ng) ? ST_ROUND : ST_APPLY;
               end else begin
                  vi_ff <= vi_ff + 1'b1;
               end
            end
            ST_ROUND: begin
               li_ff <= '0;
               vi_ff <= '0;
               if (found_ff && int'(round_ff) < MAX_STEPS) begin
                  for (int i = 0; i < MAX_VARS; i++) begin
                     if (i < int'(nv)) begin
                        cur_ff[i] <= chos_ff[i];
                     end
                  end
                  log_mem[round_ff[LAW-1:0]] <= best_ff;
                  round_ff <= round_ff + 1'b1;
                  found_ff <= 1'b0;
                  gi_ff    <= '0;
                  state_ff <= ST_APPLY;
               end else begin
                  over_ff  <= found_ff;
                  state_ff <= (round_ff != '0) ? ST_LOG_RD : ST_ELEM_OUT;
               end
            end
            ST_LOG_RD: begin
               state_ff <= ST_LOG_OUT;
            end
            ST_LOG_OUT: begin
               if (out_free) begin
                  rsp_valid     <= 1'b1;
                  rsp_kind      <= gsc_pkg::KIND_GEN;
                  rsp_position  <= 4'(int'(log_q));
                  rsp_value_out <= 3'd0;
                  rsp_overflow  <= over_ff;
                  rsp_last_out  <= 1'b0;
                  li_ff         <= li_ff + 1'b1;
                  state_ff      <= (li_ff + 1'b1 == round_ff) ? ST_ELEM_OUT : ST_LOG_RD;
               end
            end
            ST_ELEM_OUT: begin
               if (out_free) begin
                  rsp_valid     <= 1'b1;
                  rsp_kind      <= gsc_pkg::KIND_ELEM;
                  rsp_position  <= 4'(int'(vi_ff));
                  rsp_value_out <= cur_x;
                  rsp_overflow  <= over_ff;
                  rsp_last_out  <= (vi_ff + 1'b1 == nv);
                  vi_ff         <= vi_ff + 1'b1;
                  if (vi_ff + 1'b1 == nv) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_gen_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == gsc_pkg::KIND_GEN |-> rsp_value_out == 3'd0)
      else $error("generator beat carries a value");
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      int'(round_ff) <= MAX_STEPS)
      else $error("round count beyond limit");
   a_log_before_elem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOG_OUT |-> li_ff < round_ff)
      else $error("log read past round count");
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_out && !rsp_stall |-> rsp_kind == gsc_pkg::KIND_ELEM)
      else $error("final beat is not an element");
endmodule
`default_nettype wire

// ===== tb/sv/greedy_state_canonicalizer_test.sv =====
// Self-checking testbench for greedy_state_canonicalizer: loads generator tables,
// streams state vectors and checks every generator and canonical element beat
// against an in-bench predictor. Depends on gsc_pkg and the block's RTL.
`timescale 1ns / 1ps
module greedy_state_canonicalizer_test;
   localparam int NVARS = gsc_pkg::DEF_MAX_VARS;
   localparam int NGENS = gsc_pkg::DEF_MAX_GENS;
   localparam int NVALS = gsc_pkg::DEF_MAX_VALUES;
   localparam int STEP_LIMIT = gsc_pkg::DEF_MAX_STEPS;
   localparam int QUIET_LIMIT = 60000;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [1:0] ACT_NONE = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] gen;
      logic [3:0] var_idx;
      logic [2:0] value;
      logic [3:0] dest;
      logic       last;
   } req_t;

   typedef struct packed {
      logic       kind;
      logic [3:0] position;
      logic [2:0] value;
      logic       overflow;
      logic       last;
   } rsp_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_action = '0;
   logic [2:0] req_gen_index = '0;
   logic [3:0] req_var_index = '0;
   logic [2:0] req_value_in = '0;
   logic [3:0] req_mapped_to = '0;
   logic       req_last_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b1;
   logic       rsp_kind;
   logic [3:0] rsp_position;
   logic [2:0] rsp_value_out;
   logic       rsp_overflow;
   logic       rsp_last_out;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = 1'b0;
   logic [4:0] csr_data = '0;

   greedy_state_canonicalizer dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [3:0] perm_dest [NGENS][NVARS];
   logic [2:0] value_xlat [NGENS][NVARS][NVALS];
   bit         perm_loaded [NGENS][NVARS];
   bit         xlat_loaded [NGENS][NVARS][NVALS];
   logic [2:0] state_vec [NVARS];
   logic [2:0] image_vec [NVARS];
   logic [2:0] best_vec [NVARS];
   logic [4:0] var_count_reg = gsc_pkg::VAR_COUNT_RESET;
   logic [3:0] gen_count_reg = gsc_pkg::GEN_COUNT_RESET;

   rsp_t canon_results [$];
   bit   failed = 1'b0;
   bit   idling = 1'b1;
   int   hold_off = 0;
   int   items_sent = 0;

   function automatic int used_vars();
      if (var_count_reg == 0) return 1;
      if (var_count_reg > NVARS) return NVARS;
      return var_count_reg;
   endfunction

   function automatic int used_gens();
      return (gen_count_reg > NGENS) ? NGENS : gen_count_reg;
   endfunction

   function automatic bit image_smaller(int nv);
      for (int v = 0; v < nv; v++)
         if (image_vec[v] != state_vec[v]) return image_vec[v] < state_vec[v];
      return 1'b0;
   endfunction

   task automatic canonicalize_predict(input req_t it);
      int   nv;
      int   ng;
      int   best;
      int   rounds;
      bit   over;
      rsp_t r;
      rsp_t run_beats [$];
      case (it.action)
         gsc_pkg::ACT_VAR_MAP: perm_dest[it.gen][it.var_idx] = it.dest;
         gsc_pkg::ACT_VALUE_MAP: value_xlat[it.gen][it.var_idx][it.value] = it.dest[2:0];
         gsc_pkg::ACT_ELEMENT: begin
            state_vec[it.var_idx] = it.value;
            if (it.last) begin
               nv = used_vars();
               ng = used_gens();
               rounds = 0;
               over = 1'b0;
               forever begin
                  best = -1;
                  for (int g = 0; g < ng; g++) begin
                     for (int v = 0; v < nv; v++)
                        if (perm_dest[g][v] < nv)
                           image_vec[perm_dest[g][v]] = value_xlat[g][v][state_vec[v]];
                     if (image_smaller(nv)) begin
                        best_vec = image_vec;
                        best = g;
                     end
                  end
                  if (best < 0) break;
                  if (rounds >= STEP_LIMIT) begin
                     over = 1'b1;
                     break;
                  end
                  for (int v = 0; v < nv; v++) state_vec[v] = best_vec[v];
                  rounds++;
                  r = '{gsc_pkg::KIND_GEN, 4'(best), 3'd0, 1'b0, 1'b0};
                  run_beats = {run_beats, r};
               end
               for (int v = 0; v < nv; v++) begin
                  r = '{gsc_pkg::KIND_ELEM, 4'(v), state_vec[v], 1'b0, 1'b0};
                  run_beats = {run_beats, r};
               end
               foreach (run_beats[k]) run_beats[k].overflow = over;
               run_beats[run_beats.size() - 1].last = 1'b1;
               canon_results = {canon_results, run_beats};
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_beat(input req_t it);
      int gap;
      if (idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= it.action;
      req_gen_index <= it.gen;
      req_var_index <= it.var_idx;
      req_value_in  <= it.value;
      req_mapped_to <= it.dest;
      req_last_in   <= it.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      canonicalize_predict(it);
   endtask

   task automatic load_perm(input int g, input int v, input int d);
      perm_loaded[g][v] = 1'b1;
      send_beat('{gsc_pkg::ACT_VAR_MAP, 3'(g), 4'(v), 3'($urandom), 4'(d), 1'($urandom)});
   endtask

   task automatic load_xlat(input int g, input int v, input int x, input int y);
      xlat_loaded[g][v][x] = 1'b1;
      send_beat('{gsc_pkg::ACT_VALUE_MAP, 3'(g), 4'(v), 3'(x),
                  {1'($urandom), 3'(y)}, 1'($urandom)});
   endtask

   task automatic send_element(input int v, input int x, input bit last);
      send_beat('{gsc_pkg::ACT_ELEMENT, 3'($urandom), 4'(v), 3'(x), 4'($urandom), last});
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (canon_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input int data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 5'(data);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == gsc_pkg::CSR_VAR_COUNT) var_count_reg = 5'(data);
      else gen_count_reg = 4'(data);
      csr_valid <= 1'b0;
   endtask

   // fill every table entry a run can read; keep generator 0 a permutation
   task automatic ready_tables();
      int nv;
      int ng;
      int mask;
      int order [NVARS];
      int j;
      int t;
      nv = used_vars();
      ng = used_gens();
      if (ng == 0) return;
      mask = 0;
      for (int v = 0; v < nv; v++)
         if (perm_loaded[0][v] && perm_dest[0][v] < nv) mask |= 1 << perm_dest[0][v];
      if (mask != (1 << nv) - 1) begin
         for (int v = 0; v < nv; v++) order[v] = v;
         for (int v = nv - 1; v > 0; v--) begin
            j = $urandom_range(0, v);
            t = order[v];
            order[v] = order[j];
            order[j] = t;
         end
         for (int v = 0; v < nv; v++) load_perm(0, v, order[v]);
      end
      for (int g = 0; g < ng; g++)
         for (int v = 0; v < nv; v++) begin
            if (!perm_loaded[g][v]) load_perm(g, v, $urandom_range(0, 15));
            for (int x = 0; x < NVALS; x++)
               if (!xlat_loaded[g][v][x]) load_xlat(g, v, x, $urandom_range(0, 7));
         end
   endtask

   task automatic send_vector();
      int nv;
      int order [NVARS];
      int j;
      int t;
      nv = used_vars();
      for (int v = 0; v < nv; v++) order[v] = v;
      for (int v = nv - 1; v > 0; v--) begin
         j = $urandom_range(0, v);
         t = order[v];
         order[v] = order[j];
         order[j] = t;
      end
      for (int v = 0; v < nv; v++) send_element(order[v], $urandom_range(0, 7), 1'b0);
      send_element($urandom_range(0, 15), $urandom_range(0, 7), 1'b1);
   endtask

   task automatic test_identity_vector();
      for (int v = 0; v < NVARS; v++) send_element(v, (v % 2) ? 7 : 0, v == NVARS - 1);
   endtask

   // generator 0 borrows (dec elem 0, elem 1 -> 7), generator 1 decrements elem 1
   task automatic test_borrow_counter();
      write_csr(gsc_pkg::CSR_VAR_COUNT, 2);
      write_csr(gsc_pkg::CSR_GEN_COUNT, 2);
      for (int g = 0; g < 2; g++)
         for (int v = 0; v < 2; v++) load_perm(g, v, v);
      for (int x = 0; x < NVALS; x++) begin
         load_xlat(0, 0, x, (x > 0) ? x - 1 : 0);
         load_xlat(0, 1, x, 7);
         load_xlat(1, 0, x, x);
         load_xlat(1, 1, x, (x > 0) ? x - 1 : 0);
      end
      send_element(0, 1, 1'b0);
      send_element(1, 3, 1'b1);
      send_element(0, 7, 1'b0);
      send_element(1, 7, 1'b1);
   endtask

   task automatic test_count_saturation();
      write_csr(gsc_pkg::CSR_VAR_COUNT, 0);
      write_csr(gsc_pkg::CSR_GEN_COUNT, 15);
      ready_tables();
      send_element(0, 7, 1'b1);
      write_csr(gsc_pkg::CSR_VAR_COUNT, 31);
      write_csr(gsc_pkg::CSR_GEN_COUNT, 0);
      send_vector();
   endtask

   task automatic test_ignored_action();
      repeat (4)
         send_beat('{ACT_NONE, 3'($urandom), 4'($urandom), 3'($urandom),
                     4'($urandom), 1'($urandom)});
   endtask

   task automatic test_backpressure();
      write_csr(gsc_pkg::CSR_VAR_COUNT, 3);
      write_csr(gsc_pkg::CSR_GEN_COUNT, 2);
      ready_tables();
      hold_off = 400;
      repeat (5) send_vector();
   endtask

   task automatic test_random_runs();
      int goal;
      goal = items_sent + 110;
      while (items_sent < goal) begin
         if (items_sent > goal - 40) idling = 1'b0;
         if ($urandom_range(0, 2) == 0)
            write_csr(gsc_pkg::CSR_VAR_COUNT, ($urandom_range(0, 9) == 0) ?
                      0 : $urandom_range(1, 4));
         if ($urandom_range(0, 2) == 0)
            write_csr(gsc_pkg::CSR_GEN_COUNT, $urandom_range(0, 3));
         repeat ($urandom_range(0, 3))
            load_perm($urandom_range(1, 7), $urandom_range(0, 15), $urandom_range(0, 15));
         repeat ($urandom_range(0, 4))
            load_xlat($urandom_range(0, 7), $urandom_range(0, 15),
                      $urandom_range(0, 7), $urandom_range(0, 7));
         if ($urandom_range(0, 4) == 0) test_ignored_action();
         ready_tables();
         repeat ($urandom_range(1, 3)) send_vector();
      end
   endtask

   // receiver: check each beat, stall in bursts
   initial begin
      int   stall_left;
      rsp_t got;
      rsp_t want;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_kind, rsp_position, rsp_value_out, rsp_overflow, rsp_last_out};
            if (canon_results.size() == 0) begin
               $display("%0t: unexpected beat %p", $time, got);
               failed = 1'b1;
            end else begin
               want = canon_results.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
                  failed = 1'b1;
               end
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (reset) begin
            rsp_stall <= 1'b1;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 17);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: count cycles with no beat on any channel
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready) || reset)
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("greedy_state_canonicalizer_test failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity_vector();
      test_borrow_counter();
      test_count_saturation();
      test_ignored_action();
      test_backpressure();
      test_random_runs();
      drain();
      repeat (200) @(posedge clock);
      if (!failed && canon_results.size() == 0)
         $display("greedy_state_canonicalizer_test passed");
      else
         $display("greedy_state_canonicalizer_test failed");
      $finish;
   end
endmodule

// ===== files.f =====
sv/gsc_pkg.sv
sv/greedy_state_canonicalizer.sv
tb/sv/greedy_state_canonicalizer_test.sv
